// ===== hdl/nec_tx_pkg.sv =====
// ----------------------------------------------------------------------------
// nec_tx_pkg
// Shared types and fixed constants of the NEC infrared frame transmitter.
// ----------------------------------------------------------------------------
package nec_tx_pkg;

    // Frame layout: AGC pulse, one pulse per data bit, then the end pulse
    localparam int unsigned FRAME_BYTES = 4;
    localparam int unsigned BIT_PULSES  = FRAME_BYTES * 8;
    localparam int unsigned PULSE_W     = 6;
    localparam logic [PULSE_W-1:0] END_PULSE = PULSE_W'(BIT_PULSES + 1);

    // Register field widths
    localparam int unsigned CARRIER_W = 8;
    localparam int unsigned CYCLES_W  = 10;
    localparam int unsigned SPACE_W   = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 16;

    // Register reset values
    localparam logic [CARRIER_W-1:0] RST_CARRIER_HIGH = 8'd9;
    localparam logic [CARRIER_W-1:0] RST_CARRIER_LOW  = 8'd18;
    localparam logic [CYCLES_W-1:0]  RST_AGC_MARK     = 10'd341;
    localparam logic [CYCLES_W-1:0]  RST_BIT_MARK     = 10'd21;
    localparam logic [SPACE_W-1:0]   RST_AGC_SPACE    = 16'd4500;
    localparam logic [SPACE_W-1:0]   RST_ZERO_SPACE   = 16'd560;
    localparam logic [SPACE_W-1:0]   RST_ONE_SPACE    = 16'd1690;
    localparam logic [SPACE_W-1:0]   RST_END_SPACE    = 16'd4708;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CARRIER_HIGH = 3'd0,
        CFG_CARRIER_LOW  = 3'd1,
        CFG_AGC_MARK     = 3'd2,
        CFG_BIT_MARK     = 3'd3,
        CFG_AGC_SPACE    = 3'd4,
        CFG_ZERO_SPACE   = 3'd5,
        CFG_ONE_SPACE    = 3'd6,
        CFG_END_SPACE    = 3'd7
    } t_cfg_reg;

    // Transmit phase, one-hot
    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_MARK_HI = 4'b0010,
        PH_MARK_LO = 4'b0100,
        PH_SPACE   = 4'b1000
    } t_phase;

endpackage

// ===== hdl/nec_ir_frame_transmitter_top.sv =====
// ----------------------------------------------------------------------------
// nec_ir_frame_transmitter_top
// NEC infrared frame transmitter driven one time tick per input request.
// ----------------------------------------------------------------------------
// Usage:
//   Every input request is one time tick (1 us at the reset timings). A tick
//   with i_start_req high while idle latches i_device_address and i_key_code
//   and starts a frame on that same tick: AGC mark and space, 32 data bits
//   (address, ~address, command, ~command, LSB first), then an end pulse.
//   Each tick yields exactly one result request: LED level, busy flag and a
//   frame-done strobe on the last tick of the end space.
//   The tick's result sits in the output register on the cycle after the
//   tick is accepted. Throughput is one tick per cycle while the receiver
//   takes every result; per tick it does counter compares and a bit select.
//   When the receiver stalls, the output register holds its result and
//   o_in_ready drops, freezing the frame state until the result is taken.
//   Configuration writes are taken every cycle (o_cfg_ready is always high)
//   and should be made while no frame is in progress.
//   Reset (synchronous, active low) restores the default NEC timings,
//   returns the block to idle and empties the output register.
// ----------------------------------------------------------------------------
module nec_ir_frame_transmitter_top
    import nec_tx_pkg::*;
#(
    parameter int unsigned DURATION_WIDTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // tick channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_start_req,
    input  logic [7:0]           i_device_address,
    input  logic [7:0]           i_key_code,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_led_on,
    output logic                 o_busy_res,
    output logic                 o_frame_done,
    // configuration channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    // Counter compare width: wide enough for both the tick counter plus one
    // and any 16-bit space setting.
    localparam int unsigned DW = DURATION_WIDTH;
    localparam int unsigned CW = ((DW > SPACE_W) ? DW : SPACE_W) + 1;
    localparam logic [CW-1:0] TICK_LIMIT = CW'((64'd1 << DW) - 64'd1);

    // Configuration registers
    logic [CARRIER_W-1:0] r_carrier_high, r_carrier_low;
    logic [CYCLES_W-1:0]  r_agc_mark, r_bit_mark;
    logic [SPACE_W-1:0]   r_agc_space, r_zero_space, r_one_space, r_end_space;

    // Frame state
    t_phase               r_phase, n_phase;
    logic [31:0]          r_frame_bits, n_frame_bits;
    logic [PULSE_W-1:0]   r_pulse_index, n_pulse_index;
    logic [CYCLES_W-1:0]  r_cycle_count, n_cycle_count;
    logic [DW-1:0]        r_tick_count, n_tick_count;

    // Result register
    logic                 r_out_valid;
    logic                 r_led_on, r_busy_res, r_frame_done;
    logic                 n_led_on, n_busy_res, n_frame_done;

    logic                 in_acc;
    t_phase               cur_phase;
    logic [PULSE_W-1:0]   cur_pulse;
    logic [CYCLES_W-1:0]  cur_cycles;
    logic [DW-1:0]        cur_tick;
    logic [CW-1:0]        tick_next;
    logic [CW-1:0]        tick_target;
    logic                 phase_end;
    logic [CYCLES_W-1:0]  cycle_next;
    logic [CYCLES_W-1:0]  mark_cycles;
    logic [4:0]           bit_sel;
    logic [SPACE_W-1:0]   space_ticks;

    // Accept a tick whenever the result register is free or being emptied
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid  = r_out_valid;
    assign o_led_on     = r_led_on;
    assign o_busy_res   = r_busy_res;
    assign o_frame_done = r_frame_done;

    // ------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carrier_high <= RST_CARRIER_HIGH;
            r_carrier_low  <= RST_CARRIER_LOW;
            r_agc_mark     <= RST_AGC_MARK;
            r_bit_mark     <= RST_BIT_MARK;
            r_agc_space    <= RST_AGC_SPACE;
            r_zero_space   <= RST_ZERO_SPACE;
            r_one_space    <= RST_ONE_SPACE;
            r_end_space    <= RST_END_SPACE;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_CARRIER_HIGH: r_carrier_high <= i_cfg_data[CARRIER_W-1:0];
                CFG_CARRIER_LOW:  r_carrier_low  <= i_cfg_data[CARRIER_W-1:0];
                CFG_AGC_MARK:     r_agc_mark     <= i_cfg_data[CYCLES_W-1:0];
                CFG_BIT_MARK:     r_bit_mark     <= i_cfg_data[CYCLES_W-1:0];
                CFG_AGC_SPACE:    r_agc_space    <= i_cfg_data[SPACE_W-1:0];
                CFG_ZERO_SPACE:   r_zero_space   <= i_cfg_data[SPACE_W-1:0];
                CFG_ONE_SPACE:    r_one_space    <= i_cfg_data[SPACE_W-1:0];
                CFG_END_SPACE:    r_end_space    <= i_cfg_data[SPACE_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // One tick of the frame sequencer
    // ------------------------------------------------------------------
    always_comb begin
        // A start while idle loads the frame and opens the AGC mark at once
        n_frame_bits = r_frame_bits;
        if (r_phase == PH_IDLE && i_start_req) begin
            cur_phase    = PH_MARK_HI;
            cur_pulse    = '0;
            cur_cycles   = '0;
            cur_tick     = '0;
            n_frame_bits = {~i_key_code, i_key_code, ~i_device_address, i_device_address};
        end else begin
            cur_phase  = r_phase;
            cur_pulse  = r_pulse_index;
            cur_cycles = r_cycle_count;
            cur_tick   = r_tick_count;
        end

        bit_sel     = 5'(cur_pulse - PULSE_W'(1));
        mark_cycles = (cur_pulse == '0) ? r_agc_mark : r_bit_mark;
        cycle_next  = cur_cycles + CYCLES_W'(1);

        if (cur_pulse == '0) begin
            space_ticks = r_agc_space;
        end else if (cur_pulse >= END_PULSE) begin
            space_ticks = r_end_space;
        end else if (n_frame_bits[bit_sel]) begin
            space_ticks = r_one_space;
        end else begin
            space_ticks = r_zero_space;
        end

        case (cur_phase)
            PH_MARK_HI: tick_target = CW'(r_carrier_high);
            PH_MARK_LO: tick_target = CW'(r_carrier_low);
            default:    tick_target = CW'(space_ticks);
        endcase

        tick_next = CW'(cur_tick) + CW'(1);
        phase_end = (tick_next >= tick_target) || (tick_next >= TICK_LIMIT);

        n_phase       = cur_phase;
        n_pulse_index = cur_pulse;
        n_cycle_count = cur_cycles;
        n_tick_count  = phase_end ? '0 : tick_next[DW-1:0];
        n_led_on      = 1'b0;
        n_busy_res    = 1'b0;
        n_frame_done  = 1'b0;

        case (cur_phase)
            PH_IDLE: begin
                n_tick_count = cur_tick;
            end
            PH_MARK_HI: begin
                n_busy_res = 1'b1;
                n_led_on   = 1'b1;
                if (phase_end) begin
                    n_phase = PH_MARK_LO;
                end
            end
            PH_MARK_LO: begin
                n_busy_res = 1'b1;
                if (phase_end) begin
                    // A zero cycle setting, or a wrapped count, ends the mark too
                    if (cycle_next >= mark_cycles || cycle_next == '0) begin
                        n_phase       = PH_SPACE;
                        n_cycle_count = '0;
                    end else begin
                        n_phase       = PH_MARK_HI;
                        n_cycle_count = cycle_next;
                    end
                end
            end
            PH_SPACE: begin
                n_busy_res = 1'b1;
                if (phase_end) begin
                    if (cur_pulse >= END_PULSE) begin
                        n_frame_done  = 1'b1;
                        n_phase       = PH_IDLE;
                        n_pulse_index = '0;
                    end else begin
                        n_phase       = PH_MARK_HI;
                        n_pulse_index = cur_pulse + PULSE_W'(1);
                        n_cycle_count = '0;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // State and result registers: advance only on an accepted tick
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_frame_bits  <= '0;
            r_pulse_index <= '0;
            r_cycle_count <= '0;
            r_tick_count  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (in_acc) begin
                r_phase       <= n_phase;
                r_frame_bits  <= n_frame_bits;
                r_pulse_index <= n_pulse_index;
                r_cycle_count <= n_cycle_count;
                r_tick_count  <= n_tick_count;
                r_out_valid   <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_led_on     <= n_led_on;
            r_busy_res   <= n_busy_res;
            r_frame_done <= n_frame_done;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_phase_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_phase))
        else $error("phase register lost its one-hot code");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_pulse_index == '0 && r_cycle_count == '0))
        else $error("idle with pulse or cycle count left over");

    a_pulse_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pulse_index <= END_PULSE)
        else $error("pulse index beyond the end pulse");

    a_led_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_led_on || r_frame_done)) |-> r_busy_res)
        else $error("LED or frame done outside a frame");

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> ($stable(r_phase) && $stable(r_tick_count)))
        else $error("frame state moved while the result was stalled");

endmodule

// ===== tb/tb_nec_ir_frame_transmitter_top.sv =====
// ----------------------------------------------------------------------------
// tb_nec_ir_frame_transmitter_top
// Self-checking bench for the NEC infrared frame transmitter. Tick requests
// are queued per timing setting and predicted one by one. Every result
// request is compared field by field with the predicted LED level, busy flag
// and frame-done strobe.
// ----------------------------------------------------------------------------
module tb_nec_ir_frame_transmitter_top;
    import nec_tx_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DUR_W        = 16;
    localparam logic [16:0] TICK_MAX     = 17'((1 << DUR_W) - 1);
    localparam int unsigned CYCLE_LIMIT  = 200_000;
    localparam int unsigned REPORT_LIMIT = 40;

    // One tick request as the sender presents it
    typedef struct {
        bit          start;
        logic [7:0]  addr;
        logic [7:0]  key;
        int unsigned gap;   // idle cycles before the request is raised
        bit          hold;  // wait until every result is back first
    } t_tick_req;

    // Levels the block reports for one tick
    typedef struct packed {
        logic led_on;
        logic busy_res;
        logic frame_done;
    } t_led_levels;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic       tick_valid = 1'b0;
    logic       start_req  = 1'b0;
    logic [7:0] dev_addr   = 8'h00;
    logic [7:0] key_code   = 8'h00;
    logic       out_ready  = 1'b0;

    logic                 cfg_valid = 1'b0;
    t_cfg_reg             cfg_index = CFG_CARRIER_HIGH;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    logic o_in_ready;
    logic o_out_valid;
    logic o_led_on;
    logic o_busy_res;
    logic o_frame_done;
    logic o_cfg_ready;

    // Timing registers as the block should hold them
    logic [CARRIER_W-1:0] carrier_hi = RST_CARRIER_HIGH;
    logic [CARRIER_W-1:0] carrier_lo = RST_CARRIER_LOW;
    logic [CYCLES_W-1:0]  agc_cycles = RST_AGC_MARK;
    logic [CYCLES_W-1:0]  bit_cycles = RST_BIT_MARK;
    logic [SPACE_W-1:0]   agc_space  = RST_AGC_SPACE;
    logic [SPACE_W-1:0]   zero_space = RST_ZERO_SPACE;
    logic [SPACE_W-1:0]   one_space  = RST_ONE_SPACE;
    logic [SPACE_W-1:0]   end_space  = RST_END_SPACE;

    // Frame state of the predictor, idle after reset
    logic [31:0]          frame_word     = '0;
    logic [PULSE_W-1:0]   pulse_num      = '0;
    logic                 marking        = 1'b0;
    logic [CYCLES_W-1:0]  carrier_cycles = '0;
    logic                 carrier_lit    = 1'b0;
    logic [DUR_W-1:0]     phase_ticks    = '0;
    logic                 sending        = 1'b0;

    t_tick_req   pending_ticks[$];
    t_led_levels expected_levels[$];

    int unsigned ticks_queued   = 0;  // written by the stimulus process only
    int unsigned ticks_sent     = 0;  // written by the driver only
    int unsigned results_seen   = 0;  // written by the monitor only
    int unsigned mismatch_count = 0;
    int unsigned gap_count      = 0;
    int unsigned stall_left     = 0;
    int unsigned cycle_count    = 0;
    bit          steady         = 1'b1;  // no idling on either side

    nec_ir_frame_transmitter_top #(
        .DURATION_WIDTH(DUR_W)
    ) DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (tick_valid),
        .o_in_ready      (o_in_ready),
        .i_start_req     (start_req),
        .i_device_address(dev_addr),
        .i_key_code      (key_code),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_led_on        (o_led_on),
        .o_busy_res      (o_busy_res),
        .o_frame_done    (o_frame_done),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Advance the phase counter; true on the last tick of a phase of
    // target ticks. A zero target behaves as one tick, and no phase may
    // outlast the counter range.
    function automatic bit phase_done(logic [15:0] target);
        logic [16:0] nxt;
        nxt = {1'b0, phase_ticks} + 17'd1;
        if (nxt >= {1'b0, target} || nxt >= TICK_MAX) begin
            phase_ticks = '0;
            return 1'b1;
        end
        phase_ticks = nxt[DUR_W-1:0];
        return 1'b0;
    endfunction

    function automatic void start_mark();
        marking        = 1'b1;
        carrier_lit    = 1'b1;
        carrier_cycles = '0;
        phase_ticks    = '0;
    endfunction

    // Levels for one tick; updates the frame state
    function automatic t_led_levels next_led_levels(logic start, logic [7:0] addr,
                                                    logic [7:0] key);
        t_led_levels         lv;
        logic [CYCLES_W-1:0] cyc_target;
        logic [SPACE_W-1:0]  space_target;
        lv = '0;
        // Latch the bytes only when idle; a start while busy is dropped
        if (!sending && start === 1'b1) begin
            frame_word = {~key, key, ~addr, addr};
            pulse_num  = '0;
            sending    = 1'b1;
            start_mark();
        end
        if (sending) begin
            lv.busy_res = 1'b1;
            if (marking) begin
                lv.led_on = carrier_lit;
                if (carrier_lit) begin
                    if (phase_done(16'(carrier_hi)))
                        carrier_lit = 1'b0;
                end else if (phase_done(16'(carrier_lo))) begin
                    cyc_target     = (pulse_num == '0) ? agc_cycles : bit_cycles;
                    carrier_cycles = carrier_cycles + CYCLES_W'(1);
                    // A zero cycle count still gives one whole carrier cycle
                    if (carrier_cycles >= cyc_target || carrier_cycles == '0) begin
                        marking        = 1'b0;
                        carrier_cycles = '0;
                    end else begin
                        carrier_lit = 1'b1;
                    end
                end
            end else begin
                if (pulse_num == '0)
                    space_target = agc_space;
                else if (pulse_num >= END_PULSE)
                    space_target = end_space;
                else if (frame_word[5'(pulse_num - PULSE_W'(1))])
                    space_target = one_space;
                else
                    space_target = zero_space;
                if (phase_done(space_target)) begin
                    if (pulse_num >= END_PULSE) begin
                        lv.frame_done = 1'b1;
                        sending       = 1'b0;
                        pulse_num     = '0;
                        carrier_lit   = 1'b0;
                    end else begin
                        pulse_num = pulse_num + PULSE_W'(1);
                        start_mark();
                    end
                end
            end
        end
        return lv;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic int unsigned at_least_one(int unsigned v);
        return (v == 0) ? 1 : v;
    endfunction

    // Ticks from the start request to frame-done under the current timing
    function automatic int unsigned frame_ticks(logic [7:0] addr, logic [7:0] key);
        logic [31:0] word;
        int unsigned per_cycle;
        int unsigned bit_mark;
        int unsigned n;
        word      = {~key, key, ~addr, addr};
        per_cycle = at_least_one(32'(carrier_hi)) + at_least_one(32'(carrier_lo));
        bit_mark  = at_least_one(32'(bit_cycles)) * per_cycle;
        n = at_least_one(32'(agc_cycles)) * per_cycle + at_least_one(32'(agc_space))
            + bit_mark + at_least_one(32'(end_space));
        for (int b = 0; b < 32; b++)
            n += bit_mark + at_least_one(32'(word[b] ? one_space : zero_space));
        return n;
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic int unsigned mostly_one(int unsigned top);
        return ($urandom_range(0, 2) == 0) ? $urandom_range(1, top) : 1;
    endfunction

    function automatic void queue_tick(bit start, logic [7:0] addr, logic [7:0] key,
                                       bit hold = 1'b0);
        t_tick_req t;
        t.start = start;
        t.addr  = addr;
        t.key   = key;
        t.gap   = steady ? 0 : $urandom_range(0, 13);
        t.hold  = hold;
        pending_ticks.push_back(t);
        ticks_queued++;
    endfunction

    // Ticks inside a frame; about a quarter carry a start that must be dropped
    function automatic void queue_filler(int unsigned n);
        repeat (n)
            queue_tick($urandom_range(0, 3) == 0, 8'($urandom), 8'($urandom));
    endfunction

    // A whole frame: the start request, then exactly as many ticks as it lasts
    function automatic void queue_frame(logic [7:0] addr, logic [7:0] key, bit hold);
        queue_tick(1'b1, addr, key, hold);
        queue_filler(frame_ticks(addr, key) - 1);
    endfunction

    task automatic write_reg(t_cfg_reg idx, logic [CFG_DAT_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (o_cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_CARRIER_HIGH: carrier_hi = val[CARRIER_W-1:0];
            CFG_CARRIER_LOW:  carrier_lo = val[CARRIER_W-1:0];
            CFG_AGC_MARK:     agc_cycles = val[CYCLES_W-1:0];
            CFG_BIT_MARK:     bit_cycles = val[CYCLES_W-1:0];
            CFG_AGC_SPACE:    agc_space  = val;
            CFG_ZERO_SPACE:   zero_space = val;
            CFG_ONE_SPACE:    one_space  = val;
            CFG_END_SPACE:    end_space  = val;
            default: ;
        endcase
    endtask

    // Rewrite every timing register, then step to a falling edge so that
    // queueing never races the driver
    task automatic set_timing(int unsigned hi, int unsigned lo, int unsigned agc_c,
                              int unsigned bit_c, int unsigned agc_s, int unsigned zero_s,
                              int unsigned one_s, int unsigned end_s);
        write_reg(CFG_CARRIER_HIGH, CFG_DAT_W'(hi));
        write_reg(CFG_CARRIER_LOW,  CFG_DAT_W'(lo));
        write_reg(CFG_AGC_MARK,     CFG_DAT_W'(agc_c));
        write_reg(CFG_BIT_MARK,     CFG_DAT_W'(bit_c));
        write_reg(CFG_AGC_SPACE,    CFG_DAT_W'(agc_s));
        write_reg(CFG_ZERO_SPACE,   CFG_DAT_W'(zero_s));
        write_reg(CFG_ONE_SPACE,    CFG_DAT_W'(one_s));
        write_reg(CFG_END_SPACE,    CFG_DAT_W'(end_s));
        @(negedge clk);
    endtask

    // Wait until every queued tick is taken and answered, then allow slack
    // for the output register
    task automatic wait_drained();
        do @(negedge clk);
        while (ticks_sent != ticks_queued || results_seen < ticks_sent);
        repeat (4) @(negedge clk);
    endtask

    // Close a frame left running: shortest timing, then plain ticks one at a
    // time until the frame is done
    task automatic finish_frame();
        set_timing(1, 1, 1, 1, 1, 1, 1, 1);
        while (sending) begin
            queue_tick(1'b0, 8'h00, 8'h00);
            wait_drained();
        end
    endtask

    function automatic bit log_mismatch();
        mismatch_count++;
        return mismatch_count <= REPORT_LIMIT;
    endfunction

    // ------------------------------------------------------------------
    // Driver: present queued tick requests, predict each one as it is taken
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        t_tick_req   nxt;
        t_led_levels lv;
        bit          take;
        if (!rst_n) begin
            tick_valid <= 1'b0;
            gap_count  <= 0;
        end else begin
            take = tick_valid && o_in_ready;
            if (take) begin
                lv = next_led_levels(start_req, dev_addr, key_code);
                expected_levels.push_back(lv);
                ticks_sent <= ticks_sent + 1;
            end
            if (tick_valid && !take) begin
                // hold the request and its payload until taken
            end else if (pending_ticks.size() == 0) begin
                tick_valid <= 1'b0;
            end else if (gap_count < pending_ticks[0].gap) begin
                tick_valid <= 1'b0;
                gap_count  <= gap_count + 1;
            end else if (pending_ticks[0].hold && results_seen < ticks_sent + take) begin
                // hold off until every outstanding result has come back
                tick_valid <= 1'b0;
            end else begin
                nxt = pending_ticks.pop_front();
                tick_valid <= 1'b1;
                start_req  <= nxt.start;
                dev_addr   <= nxt.addr;
                key_code   <= nxt.key;
                gap_count  <= 0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: take result requests with random stalls and check them
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        t_led_levels want;
        int unsigned stall;
        if (!rst_n) begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end else if (o_out_valid === 1'b1 && out_ready) begin
            results_seen <= results_seen + 1;
            if (expected_levels.size() == 0) begin
                if (log_mismatch())
                    $error("result with no tick outstanding");
            end else begin
                want = expected_levels.pop_front();
                if (o_led_on !== want.led_on && log_mismatch())
                    $error("led_on: expected %0b, got %0b", want.led_on, o_led_on);
                if (o_busy_res !== want.busy_res && log_mismatch())
                    $error("busy_res: expected %0b, got %0b", want.busy_res, o_busy_res);
                if (o_frame_done !== want.frame_done && log_mismatch())
                    $error("frame_done: expected %0b, got %0b", want.frame_done,
                           o_frame_done);
            end
            // Draw the stall before the next result is taken
            stall = steady ? 0 : $urandom_range(0, 13);
            out_ready  <= (stall == 0);
            stall_left <= stall;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= (stall_left == 1);
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Drop the run if it hangs
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("nec_ir_frame_transmitter_top: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int unsigned rand_start;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset timing: idle ticks, then a frame at real NEC lengths that runs
        // into the AGC mark. Widen the carrier high run to its maximum part way
        // through, then close the frame at the shortest timing. Ticks inside
        // the frame carry starts that must be ignored.
        steady = 1'b1;
        queue_tick(1'b0, 8'hFF, 8'hFF);
        queue_tick(1'b0, 8'h00, 8'h00);
        queue_tick(1'b1, 8'h00, 8'hFF);
        queue_filler(60);
        wait_drained();
        set_timing(255, 1, 1, 1, 1, 1, 1, 1);
        queue_filler(260);
        wait_drained();
        finish_frame();
        queue_tick(1'b0, 8'h5A, 8'hA5);
        wait_drained();

        // Shortest legal timing with idling: back-to-back frames, so the
        // second start lands on the tick after frame-done
        steady = 1'b0;
        set_timing(1, 1, 1, 1, 1, 1, 1, 1);
        queue_frame(8'hFF, 8'h00, 1'b0);
        queue_frame(8'hA5, 8'h5A, 1'b0);
        queue_tick(1'b0, 8'h3C, 8'hC3);
        wait_drained();

        // All registers zero: every tick count and cycle count acts as one;
        // the start is held off until everything has drained
        set_timing(0, 0, 0, 0, 0, 0, 0, 0);
        queue_frame(8'h0F, 8'hF0, 1'b1);
        wait_drained();

        // Random short timings, each with a whole frame, sometimes after noise ticks
        rand_start = ticks_queued;
        while (ticks_queued - rand_start < 100) begin
            steady = ($urandom_range(0, 3) == 0);
            set_timing(mostly_one(3), mostly_one(3), mostly_one(3), mostly_one(2),
                       $urandom_range(1, 12), mostly_one(4), mostly_one(6),
                       $urandom_range(1, 8));
            if ($urandom_range(0, 2) != 0)
                repeat ($urandom_range(1, 5))
                    queue_tick(1'b0, 8'($urandom), 8'($urandom));
            queue_frame(pick_byte(), pick_byte(), $urandom_range(0, 4) == 0);
            wait_drained();
        end

        if (expected_levels.size() != 0 && log_mismatch())
            $error("%0d tick results never arrived", expected_levels.size());

        if (mismatch_count == 0)
            $display("nec_ir_frame_transmitter_top: match");
        else
            $display("nec_ir_frame_transmitter_top: mismatch");
        $finish;
    end

endmodule
